### rtl/utf16_byte_stream_decoder_unit_macros.svh
// Assertion macros shared by the UTF-16 byte stream decoder RTL.
`ifndef UTF16_BYTE_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF16_BYTE_STREAM_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define U16D_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define U16D_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define U16D_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define U16D_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/u16d_pkg.sv
// Types and constants shared by the UTF-16 byte stream decoder modules.
`default_nettype none
package u16d_pkg;
   localparam int CpW   = 21;
   localparam int QDepth = 2;
   localparam int QIdxW = $clog2(QDepth);
   localparam int QCntW = $clog2(QDepth + 1);

   localparam logic [CpW-1:0] ReplChar  = 21'h00FFFD;
   localparam logic [CpW-1:0] SuppBase  = 21'h010000;
   localparam logic [15:0]    SurrLo    = 16'hD800;
   localparam logic [15:0]    SurrHiMax = 16'hDBFF;
   localparam logic [15:0]    LowSurrLo = 16'hDC00;
   localparam logic [15:0]    SurrMax   = 16'hDFFF;

   typedef struct packed {
      logic [CpW-1:0] cp0;
      logic           rep0;
      logic [CpW-1:0] cp1;
      logic           rep1;
      logic           two;
      logic           fin;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;
endpackage
`default_nettype wire

### rtl/u16d_front.sv
// Front end: accepts bytes, joins code units, pairs surrogates and forms result records.
`default_nettype none
module u16d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  big_endian,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_input,
   input  u16d_pkg::q_status_type q_status,
   output logic                  push_valid,
   output u16d_pkg::entry_type   push_entry
);
   import u16d_pkg::*;

   logic       phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       hp_ff, hp_in;
   logic [9:0] bits_ff, bits_in;
   logic [15:0] unit;
   logic       is_low, is_high, f_valid, f_rep;
   logic [CpW-1:0] f_cp;
   logic [1:0] cnt;
   logic       accept;
   entry_type  e;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      unit    = big_endian ? {held_ff, req_data_byte} : {req_data_byte, held_ff};
      is_low  = (unit >= LowSurrLo) && (unit <= SurrMax);
      is_high = (unit >= SurrLo) && (unit <= SurrHiMax);
      f_valid = !is_high;
      f_rep   = is_low;
      f_cp    = is_low ? ReplChar : {{(CpW-16){1'b0}}, unit};
   end

   always_comb begin
      e        = '0;
      cnt      = 2'd0;
      phase_in = phase_ff;
      held_in  = held_ff;
      hp_in    = hp_ff;
      bits_in  = bits_ff;
      if (!phase_ff) begin
         held_in  = req_data_byte;
         phase_in = 1'b1;
         if (req_end_of_input) begin
            e.cp0  = ReplChar;
            e.rep0 = 1'b1;
            e.cp1  = ReplChar;
            e.rep1 = 1'b1;
            cnt    = hp_ff ? 2'd2 : 2'd1;
         end
      end else begin
         phase_in = 1'b0;
         if (hp_ff && is_low) begin
            e.cp0 = SuppBase + {1'b0, bits_ff, unit[9:0]};
            cnt   = 2'd1;
            hp_in = 1'b0;
         end else if (hp_ff) begin
            e.cp0   = ReplChar;
            e.rep0  = 1'b1;
            e.cp1   = f_cp;
            e.rep1  = f_rep;
            cnt     = f_valid ? 2'd2 : 2'd1;
            hp_in   = is_high;
            bits_in = unit[9:0];
         end else begin
            e.cp0   = f_cp;
            e.rep0  = f_rep;
            cnt     = f_valid ? 2'd1 : 2'd0;
            hp_in   = is_high;
            bits_in = unit[9:0];
         end
         if (req_end_of_input && hp_in) begin
            if (cnt == 2'd0) begin
               e.cp0  = ReplChar;
               e.rep0 = 1'b1;
               cnt    = 2'd1;
            end else begin
               e.cp1  = ReplChar;
               e.rep1 = 1'b1;
               cnt    = 2'd2;
            end
         end
      end
      if (req_end_of_input) begin
         phase_in = 1'b0;
         hp_in    = 1'b0;
      end
      e.two = (cnt == 2'd2);
      e.fin = req_end_of_input;
   end

   assign push_valid = accept && (cnt != 2'd0);
   assign push_entry = e;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         hp_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hp_ff    <= hp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
         bits_ff <= bits_in;
      end
   end
endmodule
`default_nettype wire

### rtl/u16d_queue.sv
// Short register queue of result records between the front and back ends.
`default_nettype none
module u16d_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  u16d_pkg::entry_type    push_entry,
   input  logic                   pop,
   output u16d_pkg::entry_type    head,
   output u16d_pkg::q_status_type status
);
   import u16d_pkg::*;

   entry_type        mem_ff [QDepth];
   logic [QIdxW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push_valid) begin
         wr_in = (wr_ff == QIdxW'(QDepth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QIdxW'(QDepth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push_valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ff];
   assign status.full  = (cnt_ff == QCntW'(QDepth));
   assign status.empty = (cnt_ff == '0);
endmodule
`default_nettype wire

### rtl/u16d_back.sv
// Back end: emits the one or two results of each record through an output register.
`default_nettype none
module u16d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  u16d_pkg::q_status_type q_status,
   input  u16d_pkg::entry_type    head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [20:0]            rsp_code_point,
   output logic                   rsp_replaced,
   output logic                   rsp_run_last,
   output logic                   rsp_stream_last
);
   import u16d_pkg::*;

   logic           sel_ff, sel_in;
   logic           valid_ff, valid_in;
   logic [CpW-1:0] cp_ff, cp_in;
   logic           rep_ff, rep_in, run_ff, run_in, strm_ff, strm_in;
   logic           load, emit, last_of_entry;

   assign load          = !valid_ff || rsp_ready;
   assign emit          = load && !q_status.empty;
   assign last_of_entry = sel_ff || !head.two;
   assign pop           = emit && last_of_entry;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      cp_in    = sel_ff ? head.cp1 : head.cp0;
      rep_in   = sel_ff ? head.rep1 : head.rep0;
      run_in   = last_of_entry;
      strm_in  = last_of_entry && head.fin;
      if (emit) begin
         valid_in = 1'b1;
         sel_in   = !last_of_entry;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cp_ff   <= cp_in;
         rep_ff  <= rep_in;
         run_ff  <= run_in;
         strm_ff <= strm_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_replaced    = rep_ff;
   assign rsp_run_last    = run_ff;
   assign rsp_stream_last = strm_ff;
endmodule
`default_nettype wire

### rtl/utf16_byte_stream_decoder_unit.sv
// Top level of the UTF-16 byte stream decoder: byte-order register, front, queue, back.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    data_byte, end_of_input
//   rsp      out        rsp_valid/rsp_ready    code_point, replaced, run_last, stream_last
//   csr      in         csr_valid/csr_ready    big_endian
//
// One request is taken per cycle while the two-entry record queue has room.
// Each result leaves through the output register one per cycle unless rsp_ready is low,
// so a request with two results holds the back end for both; that register sets the rate.
// Synchronous reset clears the decoder flags, queue pointers and the output valid bit.
// A stalled response side backs up the queue and then drops req_ready.
`default_nettype none
`include "utf16_byte_stream_decoder_unit_macros.svh"
module utf16_byte_stream_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_replaced,
   output logic        rsp_run_last,
   output logic        rsp_stream_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_big_endian
);
   import u16d_pkg::*;

   logic         big_endian_ff;
   logic         push_valid;
   logic         pop;
   entry_type    push_entry;
   entry_type    head;
   q_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else if (csr_valid) begin
         big_endian_ff <= csr_big_endian;
      end
   end

   u16d_front u_front (
      .clock            (clock),
      .reset            (reset),
      .big_endian       (big_endian_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .q_status         (q_status),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   u16d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   u16d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_replaced    (rsp_replaced),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_last (rsp_stream_last)
   );

   `U16D_ASSERT_IMP(a_no_overflow, clock, reset, q_status.full, !push_valid)
   `U16D_ASSERT_IMP(a_no_underflow, clock, reset, pop, !q_status.empty)
   `U16D_ASSERT_IMP(a_stream_last_ends_run, clock, reset, rsp_valid && rsp_stream_last, rsp_run_last)
   `U16D_ASSERT_IMP(a_replaced_is_fffd, clock, reset, rsp_valid && rsp_replaced, rsp_code_point == ReplChar)
   `U16D_ASSERT_IMP(a_no_surrogate_out, clock, reset, rsp_valid, (rsp_code_point < 21'h00D800) || (rsp_code_point > 21'h00DFFF))
endmodule
`default_nettype wire

### verif/utf16_byte_stream_decoder_unit_checker.sv
// Checker that predicts decoded code points from observed requests and compares the results.
`default_nettype none
module utf16_byte_stream_decoder_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [20:0] rsp_code_point,
   input  logic        rsp_replaced,
   input  logic        rsp_run_last,
   input  logic        rsp_stream_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_big_endian,
   output int          error_count,
   output int          pending_results,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import u16d_pkg::*;

   localparam int MaxReports = 30;

   typedef struct packed {
      logic [CpW-1:0] code_point;
      logic           replaced;
      logic           run_last;
      logic           stream_last;
   } cp_result_type;

   cp_result_type expected_cps[$];
   cp_result_type step_cps[$];

   logic       be_q;
   logic       phase_q;
   logic [7:0] held_q;
   logic       high_pend_q;
   logic [9:0] high_bits_q;

   task automatic emit_cp(input logic [CpW-1:0] cp, input logic repl);
      cp_result_type r;
      r.code_point = cp;
      r.replaced = repl;
      r.run_last = 1'b0;
      r.stream_last = 1'b0;
      step_cps.push_back(r);
   endtask

   task automatic take_unit(input logic [15:0] unit);
      if (unit < SurrLo || unit > SurrMax) begin
         emit_cp({5'd0, unit}, 1'b0);
      end else if (unit <= SurrHiMax) begin
         high_pend_q = 1'b1;
         high_bits_q = unit[9:0];
      end else begin
         emit_cp(ReplChar, 1'b1);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic fin);
      logic [15:0]   unit;
      cp_result_type r;
      step_cps.delete();
      if (!phase_q) begin
         held_q = b;
         phase_q = 1'b1;
         if (fin) begin
            if (high_pend_q) begin
               emit_cp(ReplChar, 1'b1);
            end
            emit_cp(ReplChar, 1'b1);
         end
      end else begin
         unit = be_q ? {held_q, b} : {b, held_q};
         phase_q = 1'b0;
         if (high_pend_q) begin
            high_pend_q = 1'b0;
            if (unit >= LowSurrLo && unit <= SurrMax) begin
               emit_cp(SuppBase + {1'b0, high_bits_q, unit[9:0]}, 1'b0);
            end else begin
               emit_cp(ReplChar, 1'b1);
               take_unit(unit);
            end
         end else begin
            take_unit(unit);
         end
         if (fin && high_pend_q) begin
            emit_cp(ReplChar, 1'b1);
         end
      end
      if (fin) begin
         phase_q = 1'b0;
         held_q = '0;
         high_pend_q = 1'b0;
         high_bits_q = '0;
      end
      for (int i = 0; i < step_cps.size(); i++) begin
         r = step_cps[i];
         if (i == step_cps.size() - 1) begin
            r.run_last = 1'b1;
            r.stream_last = fin;
         end
         expected_cps.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      cp_result_type got;
      cp_result_type want;
      if (reset) begin
         expected_cps.delete();
         be_q = 1'b0;
         phase_q = 1'b0;
         held_q = '0;
         high_pend_q = 1'b0;
         high_bits_q = '0;
         error_count <= 0;
         results_checked <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.code_point = rsp_code_point;
            got.replaced = rsp_replaced;
            got.run_last = rsp_run_last;
            got.stream_last = rsp_stream_last;
            results_checked <= results_checked + 1;
            if (expected_cps.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < MaxReports)
                  $display("%0t: unexpected result cp=%h rep=%b run=%b str=%b",
                           $time, got.code_point, got.replaced, got.run_last,
                           got.stream_last);
            end else begin
               want = expected_cps.pop_front();
               if (got !== want) begin
                  error_count <= error_count + 1;
                  if (error_count < MaxReports)
                     $display({"%0t: expected cp=%h rep=%b run=%b str=%b,",
                               " got cp=%h rep=%b run=%b str=%b"},
                              $time, want.code_point, want.replaced, want.run_last,
                              want.stream_last, got.code_point, got.replaced,
                              got.run_last, got.stream_last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            be_q = csr_big_endian;
         end
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_end_of_input);
         end
      end
      pending_results <= expected_cps.size();
   end
endmodule
`default_nettype wire

### verif/tb_utf16_byte_stream_decoder_unit.sv
// Testbench top that drives byte streams and byte-order writes into the UTF-16 decoder.
`default_nettype none
module tb_utf16_byte_stream_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import u16d_pkg::*;

   localparam int IdleLimit = 4000;
   localparam int HoldOffCycles = 300;
   localparam int PhaseBytes = 350;
   localparam int RandomPhases = 5;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [20:0] rsp_code_point;
   logic        rsp_replaced;
   logic        rsp_run_last;
   logic        rsp_stream_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_big_endian;

   int error_count;
   int pending_results;
   int results_checked;

   int  bytes_sent = 0;
   int  order_writes = 0;
   int  burst_left = 0;
   int  idle_cycles = 0;
   bit  pressure_armed = 1'b0;
   bit  tb_be = 1'b0;

   utf16_byte_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_replaced     (rsp_replaced),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_last  (rsp_stream_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_big_endian   (csr_big_endian)
   );

   utf16_byte_stream_decoder_unit_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_replaced     (rsp_replaced),
      .rsp_run_last     (rsp_run_last),
      .rsp_stream_last  (rsp_stream_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_big_endian   (csr_big_endian),
      .error_count      (error_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_input <= fin;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_unit(input logic [15:0] unit, input logic fin);
      send_request(tb_be ? unit[15:8] : unit[7:0], 1'b0);
      send_request(tb_be ? unit[7:0] : unit[15:8], fin);
   endtask

   task automatic set_byte_order(input bit be);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_big_endian <= be;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      tb_be = be;
      order_writes++;
   endtask

   initial begin
      int          mode;
      int          span;
      int          tick;
      span = 0;
      tick = 0;
      mode = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_armed) begin
            pressure_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
         end
         span--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (tick % 3 == 0);
         endcase
         tick++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
            $display("FAIL utf16_byte_stream_decoder_unit");
            $finish;
         end
      end
   end

   initial begin
      int          kind;
      int          phase_start;
      logic        fin;
      logic [15:0] unit;
      logic [15:0] hi;
      logic [15:0] lo;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_end_of_input = 1'b0;
      csr_valid = 1'b0;
      csr_big_endian = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_byte_order(1'b0);
      send_unit(16'h0000, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      send_unit(SurrLo, 1'b0);
      send_unit(LowSurrLo, 1'b0);
      send_unit(SurrHiMax, 1'b0);
      send_unit(SurrMax, 1'b0);
      send_unit(SurrLo, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(LowSurrLo, 1'b0);
      send_request(8'h41, 1'b1);
      send_unit(SurrLo, 1'b0);
      send_request(8'h41, 1'b1);
      send_unit(SurrHiMax, 1'b1);

      set_byte_order(1'b1);
      send_unit(SurrLo, 1'b0);
      send_unit(LowSurrLo, 1'b0);
      send_unit(16'hD7FF, 1'b0);
      send_unit(16'hE000, 1'b1);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         set_byte_order(phase % 2 == 0);
         if (phase == 2) pressure_armed = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PhaseBytes) begin
            kind = $urandom_range(0, 99);
            fin = ($urandom_range(0, 15) == 0);
            hi = SurrLo | 16'($urandom_range(0, 1023));
            lo = LowSurrLo | 16'($urandom_range(0, 1023));
            if (kind < 40) begin
               do unit = 16'($urandom); while (unit >= SurrLo && unit <= SurrMax);
               send_unit(unit, fin);
            end else if (kind < 70) begin
               send_unit(hi, 1'b0);
               send_unit(lo, fin);
            end else if (kind < 80) begin
               send_unit(hi, fin);
            end else if (kind < 87) begin
               send_unit(lo, fin);
            end else if (kind < 95) begin
               send_unit(16'($urandom), fin);
            end else begin
               send_request(8'($urandom), fin);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Sent %0d bytes over %0d byte-order writes in both orders,",
               bytes_sent, order_writes);
      $display("with one long output stall; checked %0d code points, %0d mismatches.",
               results_checked, error_count);
      if (error_count == 0 && pending_results == 0) begin
         $display("PASS utf16_byte_stream_decoder_unit");
      end else begin
         $display("FAIL utf16_byte_stream_decoder_unit");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/u16d_pkg.sv
rtl/u16d_front.sv
rtl/u16d_queue.sv
rtl/u16d_back.sv
rtl/utf16_byte_stream_decoder_unit.sv
verif/utf16_byte_stream_decoder_unit_checker.sv
verif/tb_utf16_byte_stream_decoder_unit.sv
